// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/skf_pkg.sv =====
// Package for the scalar Kalman filter: widths, reset values, codes and control types.
`timescale 1ns / 1ps
package skf_pkg;

   localparam int DEFAULT_FRAC_BITS = 16;

   localparam int VALUE_W = 32;   // signed estimate and measurement
   localparam int VAR_W   = 31;   // unsigned variances and noise terms
   localparam int GAIN_W  = 17;   // gain field on the result word
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   // Register reset values
   localparam logic [VAR_W-1:0]   RST_PROCESS_NOISE    = 31'd65;
   localparam logic [VAR_W-1:0]   RST_MEASURE_NOISE    = 31'd65536;
   localparam logic [VALUE_W-1:0] RST_INITIAL_ESTIMATE = 32'd0;
   localparam logic [VAR_W-1:0]   RST_INITIAL_VARIANCE = 31'd65536;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PROCESS_NOISE    = 2'd0,
      REG_MEASURE_NOISE    = 2'd1,
      REG_INITIAL_ESTIMATE = 2'd2,
      REG_INITIAL_VARIANCE = 2'd3
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRED,
      ST_DIV,
      ST_MUL_EST,
      ST_MUL_VAR,
      ST_FIN,
      ST_DONE
   } skf_state_type;

   // Strobes from the sequencer to the datapath
   typedef struct packed {
      logic load;       // word accepted: capture measurement, apply restart
      logic pred;       // predicted variance and divisor
      logic div_step;   // one quotient bit
      logic div_first;  // first quotient bit, no remainder shift
      logic mul_est;    // multiply difference by gain
      logic mul_var;    // multiply variance by one minus gain, update estimate
      logic fin;        // update variance
      logic out_load;   // load result word
   } skf_ctrl_type;

endpackage

// ===== hdl/skf_if.sv =====
// Channel interfaces for measurement words and result words.
`timescale 1ns / 1ps
interface skf_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] measurement;
   logic               restart;

   modport source (output valid, output measurement, output restart, input ready);
   modport sink   (input valid, input measurement, input restart, output ready);
endinterface

interface skf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] estimate;
   logic [30:0]        variance;
   logic [16:0]        gain;

   modport source (output valid, output estimate, output variance, output gain, input ready);
   modport sink   (input valid, input estimate, input variance, input gain, output ready);
endinterface

// ===== hdl/skf_ctrl.sv =====
// Sequencer: steps one word through prediction, division, multiplies and output.
`timescale 1ns / 1ps
module skf_ctrl
   import skf_pkg::*;
#(
   parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         out_free,
   output logic         req_ready,
   output skf_ctrl_type ctrl
);

   localparam int CNT_W = $clog2(FRAC_BITS + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);

   skf_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PRED;
         end
         ST_PRED: begin
            state_in = ST_DIV;
            cnt_in   = '0;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) state_in = ST_MUL_EST;
         end
         ST_MUL_EST: state_in = ST_MUL_VAR;
         ST_MUL_VAR: state_in = ST_FIN;
         ST_FIN:     state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready      = (state_ff == ST_IDLE);
      ctrl           = '0;
      ctrl.load      = (state_ff == ST_IDLE) && req_valid;
      ctrl.pred      = (state_ff == ST_PRED);
      ctrl.div_step  = (state_ff == ST_DIV);
      ctrl.div_first = (cnt_ff == '0);
      ctrl.mul_est   = (state_ff == ST_MUL_EST);
      ctrl.mul_var   = (state_ff == ST_MUL_VAR);
      ctrl.fin       = (state_ff == ST_FIN);
      ctrl.out_load  = (state_ff == ST_DONE) && out_free;
   end

endmodule

// ===== hdl/skf_datapath.sv =====
// Datapath: filter state, restoring divider for the gain and one shared multiplier.
`timescale 1ns / 1ps
module skf_datapath
   import skf_pkg::*;
#(
   parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  skf_ctrl_type              ctrl,
   input  logic signed [VALUE_W-1:0] measurement,
   input  logic                      restart,
   input  logic [VAR_W-1:0]          process_noise,
   input  logic [VAR_W-1:0]          measure_noise,
   input  logic [VALUE_W-1:0]        initial_estimate,
   input  logic [VAR_W-1:0]          initial_variance,
   output logic signed [VALUE_W-1:0] estimate,
   output logic [VAR_W-1:0]          variance,
   output logic [FRAC_BITS:0]        gain
);

   localparam int K_W = FRAC_BITS + 1;      // gain, 0 .. one
   localparam int B_W = FRAC_BITS + 2;      // signed gain operand
   localparam int A_W = VALUE_W + 2;        // signed difference operand
   localparam int P_W = A_W + B_W;          // product
   localparam logic [K_W-1:0] ONE_K = {1'b1, {FRAC_BITS{1'b0}}};

   logic signed [VALUE_W-1:0] z_ff;
   logic signed [VALUE_W-1:0] est_ff;
   logic [VAR_W-1:0]          var_ff;
   logic [VAR_W-1:0]          p_ff;
   logic [VALUE_W-1:0]        den_ff;
   logic [VALUE_W:0]          rem_ff;
   logic [K_W-1:0]            q_ff;
   logic signed [P_W-1:0]     prod_ff;

   logic [VALUE_W-1:0]        p_sum;
   logic [VAR_W-1:0]          p_sat;
   logic [VALUE_W-1:0]        den_in;
   logic [VALUE_W:0]          trial;
   logic [VALUE_W+1:0]        sub;
   logic                      fits;
   logic [K_W-1:0]            k;
   logic signed [A_W-1:0]     mul_a;
   logic signed [B_W-1:0]     mul_b;
   logic signed [P_W-1:0]     prod_in;
   logic signed [P_W-1:0]     prod_shr;
   logic signed [A_W-1:0]     est_sum;

   // Predicted variance, saturated, and the gain divisor
   assign p_sum  = {1'b0, var_ff} + {1'b0, process_noise};
   assign p_sat  = p_sum[VALUE_W-1] ? {VAR_W{1'b1}} : p_sum[VAR_W-1:0];
   assign den_in = {1'b0, p_sat} + {1'b0, measure_noise};

   // One restoring division step: shift, trial subtract, keep or restore
   assign trial = ctrl.div_first ? rem_ff : {rem_ff[VALUE_W-1:0], 1'b0};
   assign sub   = {1'b0, trial} - {2'b00, den_ff};
   assign fits  = !sub[VALUE_W+1];

   // Zero divisor gives zero gain
   assign k = (den_ff == '0) ? '0 : q_ff;

   // Shared multiplier: difference times gain, then variance times one minus gain
   always_comb begin
      if (ctrl.mul_est) begin
         mul_a = A_W'(z_ff) - A_W'(est_ff);
         mul_b = {1'b0, k};
      end else begin
         mul_a = {3'b000, p_ff};
         mul_b = {1'b0, ONE_K - k};
      end
   end

   assign prod_in  = P_W'(mul_a) * P_W'(mul_b);
   assign prod_shr = prod_ff >>> FRAC_BITS;
   assign est_sum  = A_W'(est_ff) + prod_shr[A_W-1:0];

   // Filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff <= RST_INITIAL_ESTIMATE;
         var_ff <= RST_INITIAL_VARIANCE;
      end else if (ctrl.load && restart) begin
         est_ff <= initial_estimate;
         var_ff <= initial_variance;
      end else if (ctrl.mul_var) begin
         est_ff <= est_sum[VALUE_W-1:0];
      end else if (ctrl.fin) begin
         var_ff <= prod_shr[VAR_W-1:0];
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (ctrl.load) z_ff <= measurement;
      if (ctrl.pred) begin
         p_ff   <= p_sat;
         den_ff <= den_in;
         rem_ff <= {2'b00, p_sat};
         q_ff   <= '0;
      end
      if (ctrl.div_step) begin
         rem_ff <= fits ? sub[VALUE_W:0] : trial;
         q_ff   <= {q_ff[K_W-2:0], fits};
      end
      if (ctrl.mul_est || ctrl.mul_var) prod_ff <= prod_in;
   end

   assign estimate = est_ff;
   assign variance = var_ff;
   assign gain     = k;

endmodule

// ===== hdl/scalar_kalman_filter_top.sv =====
// Top level of the scalar Kalman filter: channels, control registers, result register.
//
//   channel   dir   handshake          word
//   req_ch    in    valid / ready      measurement, restart
//   rsp_ch    out   valid / ready      estimate, variance, gain
//   csr_*     in    csr_write_enable   csr_index, csr_write_data
//
// A word passes through prediction, the gain divider (one quotient bit per
// cycle), both multiplies and the variance update to the result register.
// The next word is accepted once that result is loaded. Reset is synchronous
// and needs no clearing pass; control registers, filter state and the result
// valid flag take their defaults at once. A stalled result holds in the output
// register; the next word is taken while it waits; only its result waits.
`timescale 1ns / 1ps
module scalar_kalman_filter_top
   import skf_pkg::*;
#(
   parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   skf_req_if.sink               req_ch,
   skf_rsp_if.source             rsp_ch,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int K_W = FRAC_BITS + 1;
   localparam int KX_W = (K_W > GAIN_W) ? K_W : GAIN_W;

   logic [VAR_W-1:0]   process_noise_ff;
   logic [VAR_W-1:0]   measure_noise_ff;
   logic [VALUE_W-1:0] initial_estimate_ff;
   logic [VAR_W-1:0]   initial_variance_ff;

   logic                      rsp_valid_ff;
   logic signed [VALUE_W-1:0] rsp_estimate_ff;
   logic [VAR_W-1:0]          rsp_variance_ff;
   logic [GAIN_W-1:0]         rsp_gain_ff;

   skf_ctrl_type              ctrl;
   logic                      out_free;
   logic signed [VALUE_W-1:0] estimate;
   logic [VAR_W-1:0]          variance;
   logic [K_W-1:0]            gain;
   logic [KX_W-1:0]           gain_ext;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         process_noise_ff    <= RST_PROCESS_NOISE;
         measure_noise_ff    <= RST_MEASURE_NOISE;
         initial_estimate_ff <= RST_INITIAL_ESTIMATE;
         initial_variance_ff <= RST_INITIAL_VARIANCE;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_PROCESS_NOISE:    process_noise_ff    <= csr_write_data[VAR_W-1:0];
            REG_MEASURE_NOISE:    measure_noise_ff    <= csr_write_data[VAR_W-1:0];
            REG_INITIAL_ESTIMATE: initial_estimate_ff <= csr_write_data;
            REG_INITIAL_VARIANCE: initial_variance_ff <= csr_write_data[VAR_W-1:0];
            default: ;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   skf_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .out_free  (out_free),
      .req_ready (req_ch.ready),
      .ctrl      (ctrl)
   );

   skf_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .measurement      (req_ch.measurement),
      .restart          (req_ch.restart),
      .process_noise    (process_noise_ff),
      .measure_noise    (measure_noise_ff),
      .initial_estimate (initial_estimate_ff),
      .initial_variance (initial_variance_ff),
      .estimate         (estimate),
      .variance         (variance),
      .gain             (gain)
   );

   // Fit the gain to the result field
   assign gain_ext = KX_W'(gain);

   // Result register: load a finished word, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         rsp_estimate_ff <= estimate;
         rsp_variance_ff <= variance;
         rsp_gain_ff     <= gain_ext[GAIN_W-1:0];
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.estimate = rsp_estimate_ff;
   assign rsp_ch.variance = rsp_variance_ff;
   assign rsp_ch.gain     = rsp_gain_ff;

endmodule

// ===== hdl/skf_checker.sv =====
// Port-level checker for the scalar Kalman filter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module skf_checker
   import skf_pkg::*;
#(
   parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [VALUE_W-1:0] rsp_estimate,
   input logic [VAR_W-1:0]          rsp_variance,
   input logic [GAIN_W-1:0]         rsp_gain
);

   localparam int GAIN_ONE_INT = (FRAC_BITS > 16) ? 0 : (1 << FRAC_BITS);
   localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(GAIN_ONE_INT);

   logic req_accept;
   assign req_accept = req_valid && req_ready;

   // A stalled result word holds its value
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_estimate) && $stable(rsp_variance) && $stable(rsp_gain), "stalled result word changed")

   // Busy right after a word is taken, and no fresh result that soon
   `ASSERT_CLK(a_busy_after_accept, clock, reset, req_accept |=> !req_ready && !$rose(rsp_valid), "not busy after accepting a word")

   // Gain never exceeds one
   `ASSERT_CLK(a_gain_bound, clock, reset, rsp_valid |-> (FRAC_BITS > 16) || (rsp_gain <= GAIN_ONE), "gain above one")

   // Reset empties the result register
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind scalar_kalman_filter_top skf_checker #(.FRAC_BITS(FRAC_BITS)) u_skf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_estimate (rsp_ch.estimate),
   .rsp_variance (rsp_ch.variance),
   .rsp_gain     (rsp_ch.gain)
);
